@@ rtl/ppm_pkg.sv @@
// ----------------------------------------------------------------------------
// ppm_pkg
// Shared types and constants for the pedal plausibility monitor.
// ----------------------------------------------------------------------------
package ppm_pkg;

  localparam int ADC_BITS      = 12;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int COUNT_BITS    = 16;
  localparam int DRIVE_BITS    = 16;
  localparam int CAUSE_BITS    = 4;
  localparam int MODE_BITS     = 2;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_PEDAL1_MIN  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEDAL1_MAX  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEDAL2_MIN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_PEDAL2_MAX  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_BRAKE_MIN   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_BRAKE_MAX   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_FAULT_LIMIT = 3'd6;

  // register reset values
  localparam logic [ADC_BITS-1:0]   PEDAL_MIN_RST   = 12'd410;
  localparam logic [ADC_BITS-1:0]   PEDAL_MAX_RST   = 12'd3686;
  localparam logic [ADC_BITS-1:0]   BRAKE_MIN_RST   = 12'd1065;
  localparam logic [ADC_BITS-1:0]   BRAKE_MAX_RST   = 12'd2458;
  localparam logic [COUNT_BITS-1:0] FAULT_LIMIT_RST = 16'd100;

  // fault causes, in priority order
  localparam logic [CAUSE_BITS-1:0] CAUSE_NONE      = 4'd0;
  localparam logic [CAUSE_BITS-1:0] CAUSE_MISMATCH  = 4'd1;
  localparam logic [CAUSE_BITS-1:0] CAUSE_P1_HIGH   = 4'd2;
  localparam logic [CAUSE_BITS-1:0] CAUSE_P2_HIGH   = 4'd3;
  localparam logic [CAUSE_BITS-1:0] CAUSE_P1_LOW    = 4'd4;
  localparam logic [CAUSE_BITS-1:0] CAUSE_P2_LOW    = 4'd5;
  localparam logic [CAUSE_BITS-1:0] CAUSE_BRK_HIGH  = 4'd6;
  localparam logic [CAUSE_BITS-1:0] CAUSE_BRK_LOW   = 4'd7;
  localparam logic [CAUSE_BITS-1:0] CAUSE_BRK_PLAUS = 4'd8;

  localparam logic [MODE_BITS-1:0] MODE_TORQUE = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_GRACE  = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_FAULT  = 2'd2;

  typedef enum logic [1:0] {
    LANE_PEDAL1,
    LANE_PEDAL2,
    LANE_BRAKE
  } lane_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_RUN,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] pedal1_code;
    logic [ADC_BITS-1:0] pedal2_code;
    logic [ADC_BITS-1:0] brake_code;
  } in_word_t;

  typedef struct packed {
    logic [DRIVE_BITS-1:0] drive;
    logic [MODE_BITS-1:0]  mode;
    logic [CAUSE_BITS-1:0] fault_cause;
    logic                  brake_latched;
  } out_word_t;

  typedef struct packed {
    logic  capture;
    logic  div_start;
    logic  lane_write;
    lane_t lane;
    logic  commit;
  } ppm_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
  } ppm_stat_t;

endpackage

@@ rtl/ppm_div.sv @@
// ----------------------------------------------------------------------------
// ppm_div
// Restoring divider, one quotient bit per cycle. Computes
// (num << FRAC_BITS) / den for num < den.
// ----------------------------------------------------------------------------
module ppm_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ppm_pkg::ADC_BITS-1:0]  num,
  input  logic [ppm_pkg::ADC_BITS-1:0]  den,
  output logic                          done,
  output logic [FRAC_BITS-1:0]          quo
);

  localparam int AW    = ppm_pkg::ADC_BITS;
  localparam int CNT_W = $clog2(FRAC_BITS + 1);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [AW-1:0]     rem;
  logic [AW-1:0]     dsr;
  logic [AW:0]       shifted;
  logic [AW:0]       diff;
  logic              take;

  assign shifted = {rem, 1'b0};
  assign diff    = shifted - {1'b0, dsr};
  assign take    = (shifted >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNT_W'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(FRAC_BITS);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= num;
      dsr <= den;
      quo <= '0;
    end else if (busy) begin
      rem <= take ? diff[AW-1:0] : shifted[AW-1:0];
      quo <= {quo[FRAC_BITS-2:0], take};
    end
  end

endmodule

@@ rtl/ppm_dp.sv @@
// ----------------------------------------------------------------------------
// ppm_dp
// Datapath: config registers, sample capture, normalization lanes,
// plausibility checks, fault timer, brake latch and output register.
// ----------------------------------------------------------------------------
module ppm_dp #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_valid,
  input  logic [ppm_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [ppm_pkg::CFG_DATA_BITS-1:0]     cfg_data,
  input  ppm_pkg::in_word_t                     in_data,
  input  ppm_pkg::ppm_cmd_t                     cmd,
  output ppm_pkg::ppm_stat_t                    stat,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output ppm_pkg::out_word_t                    out_data
);

  localparam int AW = ppm_pkg::ADC_BITS;
  localparam int CW = ppm_pkg::COUNT_BITS;
  localparam int W  = FRAC_BITS + 5;
  localparam logic [FRAC_BITS-1:0] FULL_SCALE = {FRAC_BITS{1'b1}};
  localparam logic [W-1:0] ONE_Q   = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] QUARTER = ONE_Q >> 2;

  logic [AW-1:0] p1_min, p1_max, p2_min, p2_max, brk_min, brk_max;
  logic [CW-1:0] fault_limit;
  logic [CW-1:0] fault_count, fault_count_next;
  logic          brake_latch, brake_latch_next;

  logic [AW-1:0] c1, c2, cb;
  logic [FRAC_BITS-1:0] a1, a2, b;

  // ---- config ----
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_min      <= ppm_pkg::PEDAL_MIN_RST;
      p1_max      <= ppm_pkg::PEDAL_MAX_RST;
      p2_min      <= ppm_pkg::PEDAL_MIN_RST;
      p2_max      <= ppm_pkg::PEDAL_MAX_RST;
      brk_min     <= ppm_pkg::BRAKE_MIN_RST;
      brk_max     <= ppm_pkg::BRAKE_MAX_RST;
      fault_limit <= ppm_pkg::FAULT_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ppm_pkg::REG_PEDAL1_MIN:  p1_min      <= cfg_data[AW-1:0];
        ppm_pkg::REG_PEDAL1_MAX:  p1_max      <= cfg_data[AW-1:0];
        ppm_pkg::REG_PEDAL2_MIN:  p2_min      <= cfg_data[AW-1:0];
        ppm_pkg::REG_PEDAL2_MAX:  p2_max      <= cfg_data[AW-1:0];
        ppm_pkg::REG_BRAKE_MIN:   brk_min     <= cfg_data[AW-1:0];
        ppm_pkg::REG_BRAKE_MAX:   brk_max     <= cfg_data[AW-1:0];
        ppm_pkg::REG_FAULT_LIMIT: fault_limit <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  // ---- capture ----
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c1 <= in_data.pedal1_code;
      c2 <= in_data.pedal2_code;
      cb <= in_data.brake_code;
    end
  end

  // ---- lane select and divider ----
  logic [AW-1:0] l_code, l_lo, l_hi;
  logic          div_done;
  logic [FRAC_BITS-1:0] div_quo;
  logic [FRAC_BITS-1:0] lane_val;

  always_comb begin
    case (cmd.lane)
      ppm_pkg::LANE_PEDAL1: begin
        l_code = c1; l_lo = p1_min; l_hi = p1_max;
      end
      ppm_pkg::LANE_PEDAL2: begin
        l_code = c2; l_lo = p2_min; l_hi = p2_max;
      end
      ppm_pkg::LANE_BRAKE: begin
        l_code = cb; l_lo = brk_min; l_hi = brk_max;
      end
      default: begin
        l_code = c1; l_lo = p1_min; l_hi = p1_max;
      end
    endcase
  end

  ppm_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (l_code - l_lo),
    .den   (l_hi - l_lo),
    .done  (div_done),
    .quo   (div_quo)
  );

  // clamps; also covers max not above min
  always_comb begin
    if (l_code <= l_lo) begin
      lane_val = '0;
    end else if (l_code >= l_hi) begin
      lane_val = FULL_SCALE;
    end else begin
      lane_val = div_quo;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lane_write) begin
      case (cmd.lane)
        ppm_pkg::LANE_PEDAL1: a1 <= lane_val;
        ppm_pkg::LANE_PEDAL2: a2 <= lane_val;
        ppm_pkg::LANE_BRAKE:  b  <= lane_val;
        default: ;
      endcase
    end
  end

  // ---- plausibility ----
  logic [W-1:0] a1x10, a2x11, a2x9, a1x20, bx10;
  logic [ppm_pkg::CAUSE_BITS-1:0] cause, cause_out;
  logic [ppm_pkg::MODE_BITS-1:0]  mode;
  logic [ppm_pkg::DRIVE_BITS-1:0] drive_q16;

  assign a1x10 = W'(a1) * W'(10);
  assign a2x11 = W'(a2) * W'(11);
  assign a2x9  = W'(a2) * W'(9);
  assign a1x20 = W'(a1) * W'(20);
  assign bx10  = W'(b) * W'(10);

  always_comb begin
    if (a1x10 > a2x11 || a1x10 < a2x9) cause = ppm_pkg::CAUSE_MISMATCH;
    else if (c1 > p1_max)              cause = ppm_pkg::CAUSE_P1_HIGH;
    else if (c2 > p2_max)              cause = ppm_pkg::CAUSE_P2_HIGH;
    else if (c1 < p1_min)              cause = ppm_pkg::CAUSE_P1_LOW;
    else if (c2 < p2_min)              cause = ppm_pkg::CAUSE_P2_LOW;
    else if (cb > brk_max)             cause = ppm_pkg::CAUSE_BRK_HIGH;
    else if (cb < brk_min)             cause = ppm_pkg::CAUSE_BRK_LOW;
    else                               cause = ppm_pkg::CAUSE_NONE;

    if (cause != ppm_pkg::CAUSE_NONE) begin
      fault_count_next = (fault_count == {CW{1'b1}}) ? fault_count
                                                     : fault_count + CW'(1);
    end else begin
      fault_count_next = '0;
    end

    if (W'(a1) > QUARTER && bx10 > ONE_Q) begin
      brake_latch_next = 1'b1;
    end else if (brake_latch && a1x20 < ONE_Q) begin
      brake_latch_next = 1'b0;
    end else begin
      brake_latch_next = brake_latch;
    end

    if (fault_count_next > fault_limit || brake_latch_next) begin
      mode = ppm_pkg::MODE_FAULT;
    end else if (cause != ppm_pkg::CAUSE_NONE) begin
      mode = ppm_pkg::MODE_GRACE;
    end else begin
      mode = ppm_pkg::MODE_TORQUE;
    end

    if (cause == ppm_pkg::CAUSE_NONE && brake_latch_next) begin
      cause_out = ppm_pkg::CAUSE_BRK_PLAUS;
    end else begin
      cause_out = cause;
    end
  end

  // rescale to Q0.16
  generate
    if (FRAC_BITS >= ppm_pkg::DRIVE_BITS) begin : g_drv_trunc
      assign drive_q16 = a1[FRAC_BITS-1 -: ppm_pkg::DRIVE_BITS];
    end else begin : g_drv_pad
      assign drive_q16 = {a1, {(ppm_pkg::DRIVE_BITS-FRAC_BITS){1'b0}}};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_count <= '0;
      brake_latch <= 1'b0;
    end else if (cmd.commit) begin
      fault_count <= fault_count_next;
      brake_latch <= brake_latch_next;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data.drive         <= (mode == ppm_pkg::MODE_FAULT) ? '0 : drive_q16;
      out_data.mode          <= mode;
      out_data.fault_cause   <= cause_out;
      out_data.brake_latched <= brake_latch_next;
    end
  end

  assign stat.div_done = div_done;
  assign stat.out_busy = out_valid && !out_ready;

endmodule

@@ rtl/ppm_ctrl.sv @@
// ----------------------------------------------------------------------------
// ppm_ctrl
// Sequencer: accepts a word, runs three normalizations through the shared
// divider, then commits the result into the output register.
// ----------------------------------------------------------------------------
module ppm_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ppm_pkg::ppm_stat_t stat,
  output ppm_pkg::ppm_cmd_t  cmd
);

  ppm_pkg::state_t state, state_next;
  ppm_pkg::lane_t  lane, lane_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ppm_pkg::ST_IDLE;
      lane  <= ppm_pkg::LANE_PEDAL1;
    end else begin
      state <= state_next;
      lane  <= lane_next;
    end
  end

  always_comb begin
    state_next     = state;
    lane_next      = lane;
    in_ready       = 1'b0;
    cmd.capture    = 1'b0;
    cmd.div_start  = 1'b0;
    cmd.lane_write = 1'b0;
    cmd.lane       = lane;
    cmd.commit     = 1'b0;
    case (state)
      ppm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          lane_next   = ppm_pkg::LANE_PEDAL1;
          state_next  = ppm_pkg::ST_START;
        end
      end
      ppm_pkg::ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ppm_pkg::ST_RUN;
      end
      ppm_pkg::ST_RUN: begin
        if (stat.div_done) begin
          cmd.lane_write = 1'b1;
          case (lane)
            ppm_pkg::LANE_PEDAL1: begin
              lane_next  = ppm_pkg::LANE_PEDAL2;
              state_next = ppm_pkg::ST_START;
            end
            ppm_pkg::LANE_PEDAL2: begin
              lane_next  = ppm_pkg::LANE_BRAKE;
              state_next = ppm_pkg::ST_START;
            end
            default: begin
              state_next = ppm_pkg::ST_EMIT;
            end
          endcase
        end
      end
      ppm_pkg::ST_EMIT: begin
        // wait for the output register to free up
        if (!stat.out_busy) begin
          cmd.commit = 1'b1;
          state_next = ppm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ppm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/pedal_plausibility_monitor.sv @@
// ----------------------------------------------------------------------------
// pedal_plausibility_monitor
// Accelerator pedal plausibility check with fault timer and brake latch.
// ----------------------------------------------------------------------------
// Sequence: the captured word runs START and RUN per lane, then EMIT commits it.
// Inputs: no new word is accepted until the last one is committed, as the single shared
//   bit-serial divider runs the three normalizations in turn.
// A finished word waits in the output register; the next word is accepted.
// Reset (synchronous): registers return to defaults, fault timer and brake
//   latch clear, no output pending.
// ----------------------------------------------------------------------------
module pedal_plausibility_monitor #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ppm_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [ppm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  ppm_pkg::in_word_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output ppm_pkg::out_word_t                out_data
);

  ppm_pkg::ppm_cmd_t  cmd;
  ppm_pkg::ppm_stat_t stat;

  assign cfg_ready = 1'b1;

  ppm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ppm_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
